/* rtl/core/budgeted_chunk_upload_scheduler_defines.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef BUDGETED_CHUNK_UPLOAD_SCHEDULER_DEFINES_SVH
`define BUDGETED_CHUNK_UPLOAD_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define BCUS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define BCUS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bcus_pkg.sv */
// Package with the types and constants of the chunk upload scheduler.
`default_nettype none
package bcus_pkg;

    localparam int unsigned BUFFER_QUEUE_DEPTH_DEF = 8;
    localparam int unsigned IMAGE_QUEUE_DEPTH_DEF  = 8;
    localparam logic [23:0] FRAME_BUDGET_RESET     = 24'd1048576;

    localparam logic [1:0] CMD_BUF  = 2'd0;
    localparam logic [1:0] CMD_IMG  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] TGT_VERTEX = 2'd0;
    localparam logic [1:0] TGT_INDEX  = 2'd1;
    localparam logic [1:0] TGT_IMAGE  = 2'd2;

    localparam logic [1:0] STAT_NONE = 2'd0;
    localparam logic [1:0] STAT_BUSY = 2'd1;
    localparam logic [1:0] STAT_DONE = 2'd2;

    typedef struct packed {
        logic [7:0]  tag;
        logic [23:0] vtot;
        logic [23:0] itot;
        logic [23:0] vdone;
        logic [23:0] idone;
    } buf_entry_t;

    typedef struct packed {
        logic [7:0]  tag;
        logic [13:0] width;
        logic [13:0] height;
        logic        rgba;
        logic        pix;
        logic [13:0] rows;
    } img_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BRD,
        S_BVTX,
        S_BIDX,
        S_IRD,
        S_ICHK,
        S_IDIV,
        S_IROW,
        S_STAT
    } state_t;

endpackage
`default_nettype wire

/* rtl/core/bcus_div.sv */
// Restoring divider of the budget by the bytes per row, one quotient bit per cycle.
`default_nettype none
module bcus_div
    import bcus_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [23:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [23:0]      quotient,
    output logic [15:0]      remainder
);

    logic [23:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [16:0] rem_shift;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_shift = {rem_reg[15:0], quo_reg[23]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = 5'd0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_shift >= {1'b0, dsr_reg})
            begin
                rem_next = rem_shift - {1'b0, dsr_reg};
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[15:0];

endmodule
`default_nettype wire

/* rtl/core/budgeted_chunk_upload_scheduler.sv */
// Top level of the budgeted chunk upload scheduler with its two job queues.
//
// A request is taken when start is high and busy is low. An enqueue request
// (buffer or image job) writes the queue memory and returns one result in the
// next cycle, with accepted low when the queue was full; busy stays low.
// A frame tick with jobs queued loads frame_budget and walks the buffer
// queue, then the image queue. A buffer job is visited in S_BRD, S_BVTX and
// S_BIDX, an image job in S_IRD, S_ICHK, S_IDIV and S_IROW, where the
// bit-serial divider turns the budget into rows. A tick with empty queues
// leaves busy low. Results come one per cycle at most, each marked by
// result_strobe for one cycle, and the tick ends with a status result that
// has last set. The receiver cannot stall the results.
// The config channel (cfg_valid, cfg_ready, cfg_data) writes frame_budget and
// is always ready. Reset empties both queues and sets frame_budget to its
// default; queue entries are not cleared and need no clearing pass.
`default_nettype none
`include "budgeted_chunk_upload_scheduler_defines.svh"
module budgeted_chunk_upload_scheduler
    import bcus_pkg::*;
#(
    parameter int unsigned BUFFER_QUEUE_DEPTH = BUFFER_QUEUE_DEPTH_DEF,
    parameter int unsigned IMAGE_QUEUE_DEPTH  = IMAGE_QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  job_tag,
    input  wire logic [23:0] vertex_bytes,
    input  wire logic [23:0] index_bytes,
    input  wire logic [13:0] image_width,
    input  wire logic [13:0] image_height,
    input  wire logic        image_rgba,
    input  wire logic        has_pixels,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [23:0] cfg_data,
    output logic             result_strobe,
    output logic             transfer_valid,
    output logic [7:0]       out_tag,
    output logic [1:0]       target,
    output logic [23:0]      chunk_offset,
    output logic [23:0]      chunk_length,
    output logic             job_done,
    output logic             accepted,
    output logic [1:0]       status,
    output logic             last
);

    localparam int unsigned BAW = (BUFFER_QUEUE_DEPTH > 1) ? $clog2(BUFFER_QUEUE_DEPTH) : 1;
    localparam int unsigned IAW = (IMAGE_QUEUE_DEPTH > 1) ? $clog2(IMAGE_QUEUE_DEPTH) : 1;
    localparam int unsigned BCW = $clog2(BUFFER_QUEUE_DEPTH + 1);
    localparam int unsigned ICW = $clog2(IMAGE_QUEUE_DEPTH + 1);
    localparam logic [BCW:0] BDEPTH = (BCW + 1)'(BUFFER_QUEUE_DEPTH);
    localparam logic [ICW:0] IDEPTH = (ICW + 1)'(IMAGE_QUEUE_DEPTH);
    localparam logic [BAW-1:0] BLAST = BAW'(BUFFER_QUEUE_DEPTH - 1);
    localparam logic [IAW-1:0] ILAST = IAW'(IMAGE_QUEUE_DEPTH - 1);

    state_t state_reg, state_next;

    buf_entry_t bmem [BUFFER_QUEUE_DEPTH];
    img_entry_t imem [IMAGE_QUEUE_DEPTH];
    buf_entry_t brd_reg;
    img_entry_t ird_reg;

    logic [BAW-1:0] bhead_reg, bhead_next;
    logic [BCW-1:0] bcount_reg, bcount_next;
    logic [IAW-1:0] ihead_reg, ihead_next;
    logic [ICW-1:0] icount_reg, icount_next;
    logic [23:0]    budget_reg, budget_next;
    logic [23:0]    fbudget_reg;
    logic [23:0]    wv_reg, wv_next;
    logic [15:0]    bpr_reg, bpr_next;

    logic           strobe_reg, strobe_next;
    logic           tv_reg, tv_next;
    logic [7:0]     tag_reg, tag_next;
    logic [1:0]     tgt_reg, tgt_next;
    logic [23:0]    off_reg, off_next;
    logic [23:0]    len_reg, len_next;
    logic           jd_reg, jd_next;
    logic           acc_reg, acc_next;
    logic [1:0]     stat_reg, stat_next;
    logic           last_reg, last_next;

    logic           bwr_en, iwr_en, brd_en, ird_en;
    logic [BAW-1:0] bwr_addr;
    logic [IAW-1:0] iwr_addr;
    buf_entry_t     bwr_data;
    img_entry_t     iwr_data;

    logic [BCW:0]   bsum;
    logic [ICW:0]   isum;
    logic [BAW-1:0] btail;
    logic [IAW-1:0] itail;
    logic           req;

    logic [23:0]    vrem, vc, irem, ic, wi;
    logic [15:0]    bpr_calc;
    logic [13:0]    rrem, rows_n, rows_new;
    logic [29:0]    prod;
    logic           div_start, div_done;
    logic [23:0]    div_q;
    logic [15:0]    div_r;

    assign req       = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign bsum  = {1'b0, BCW'(bhead_reg)} + {1'b0, bcount_reg};
    assign isum  = {1'b0, ICW'(ihead_reg)} + {1'b0, icount_reg};
    assign btail = (bsum >= BDEPTH) ? BAW'(bsum - BDEPTH) : BAW'(bsum);
    assign itail = (isum >= IDEPTH) ? IAW'(isum - IDEPTH) : IAW'(isum);

    bcus_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (budget_reg),
        .divisor   (bpr_calc),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req && cmd == CMD_TICK && (bcount_reg != '0 || icount_reg != '0))
                begin
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                if (budget_reg == '0 || bcount_reg == '0)
                begin
                    state_next = S_IRD;
                end
                else
                begin
                    state_next = S_BVTX;
                end
            end
            S_BVTX:
            begin
                state_next = S_BIDX;
            end
            S_BIDX:
            begin
                state_next = S_BRD;
            end
            S_IRD:
            begin
                if (budget_reg == '0 || icount_reg == '0)
                begin
                    state_next = S_STAT;
                end
                else
                begin
                    state_next = S_ICHK;
                end
            end
            S_ICHK:
            begin
                if (bpr_calc == '0 || ird_reg.height == '0 || !ird_reg.pix
                    || ird_reg.rows >= ird_reg.height)
                begin
                    state_next = S_IRD;
                end
                else
                begin
                    state_next = S_IDIV;
                end
            end
            S_IDIV:
            begin
                if (div_done)
                begin
                    state_next = S_IROW;
                end
            end
            S_IROW:
            begin
                state_next = S_IRD;
            end
            S_STAT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bhead_next  = bhead_reg;
        bcount_next = bcount_reg;
        ihead_next  = ihead_reg;
        icount_next = icount_reg;
        budget_next = budget_reg;
        wv_next     = wv_reg;
        bpr_next    = bpr_reg;
        strobe_next = 1'b0;
        tv_next     = 1'b0;
        tag_next    = '0;
        tgt_next    = TGT_VERTEX;
        off_next    = '0;
        len_next    = '0;
        jd_next     = 1'b0;
        acc_next    = 1'b0;
        stat_next   = STAT_NONE;
        last_next   = 1'b0;
        bwr_en      = 1'b0;
        iwr_en      = 1'b0;
        brd_en      = 1'b0;
        ird_en      = 1'b0;
        bwr_addr    = btail;
        iwr_addr    = itail;
        bwr_data    = '{tag: job_tag, vtot: vertex_bytes, itot: index_bytes,
                        vdone: 24'd0, idone: 24'd0};
        iwr_data    = '{tag: job_tag, width: image_width, height: image_height,
                        rgba: image_rgba, pix: has_pixels, rows: 14'd0};
        div_start   = 1'b0;

        vrem     = brd_reg.vtot - brd_reg.vdone;
        vc       = (vrem < budget_reg) ? vrem : budget_reg;
        irem     = brd_reg.itot - brd_reg.idone;
        ic       = (irem < budget_reg) ? irem : budget_reg;
        wi       = brd_reg.idone;
        bpr_calc = ird_reg.rgba ? {ird_reg.width, 2'b00}
                                : ({2'b00, ird_reg.width} + {1'b0, ird_reg.width, 1'b0});
        rrem     = ird_reg.height - ird_reg.rows;
        prod     = 30'(rrem) * 30'(bpr_reg);
        rows_n   = rrem;
        rows_new = ird_reg.rows;

        case (state_reg)
            S_IDLE:
            begin
                if (req)
                begin
                    case (cmd)
                        CMD_BUF:
                        begin
                            strobe_next = 1'b1;
                            tag_next    = job_tag;
                            last_next   = 1'b1;
                            if ({1'b0, bcount_reg} < BDEPTH)
                            begin
                                bwr_en      = 1'b1;
                                bcount_next = bcount_reg + 1'b1;
                                acc_next    = 1'b1;
                            end
                        end
                        CMD_IMG:
                        begin
                            strobe_next = 1'b1;
                            tag_next    = job_tag;
                            last_next   = 1'b1;
                            if ({1'b0, icount_reg} < IDEPTH)
                            begin
                                iwr_en      = 1'b1;
                                icount_next = icount_reg + 1'b1;
                                acc_next    = 1'b1;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (bcount_reg == '0 && icount_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                budget_next = fbudget_reg;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            S_BRD:
            begin
                brd_en = (budget_reg != '0) && (bcount_reg != '0);
            end
            S_BVTX:
            begin
                wv_next = brd_reg.vdone;
                if (brd_reg.vdone < brd_reg.vtot)
                begin
                    strobe_next = 1'b1;
                    tv_next     = 1'b1;
                    tag_next    = brd_reg.tag;
                    tgt_next    = TGT_VERTEX;
                    off_next    = brd_reg.vdone;
                    len_next    = vc;
                    jd_next     = (vc == vrem) && (brd_reg.idone == brd_reg.itot);
                    wv_next     = brd_reg.vdone + vc;
                    budget_next = budget_reg - vc;
                end
            end
            S_BIDX:
            begin
                if (budget_reg != '0 && brd_reg.idone < brd_reg.itot)
                begin
                    strobe_next = 1'b1;
                    tv_next     = 1'b1;
                    tag_next    = brd_reg.tag;
                    tgt_next    = TGT_INDEX;
                    off_next    = brd_reg.idone;
                    len_next    = ic;
                    jd_next     = (ic == irem);
                    wi          = brd_reg.idone + ic;
                    budget_next = budget_reg - ic;
                end
                bwr_en   = 1'b1;
                bwr_addr = bhead_reg;
                bwr_data = '{tag: brd_reg.tag, vtot: brd_reg.vtot, itot: brd_reg.itot,
                             vdone: wv_reg, idone: wi};
                if (wv_reg == brd_reg.vtot && wi == brd_reg.itot)
                begin
                    bhead_next  = (bhead_reg == BLAST) ? '0 : bhead_reg + 1'b1;
                    bcount_next = bcount_reg - 1'b1;
                end
            end
            S_IRD:
            begin
                ird_en = (budget_reg != '0) && (icount_reg != '0);
            end
            S_ICHK:
            begin
                bpr_next = bpr_calc;
                if (bpr_calc == '0 || ird_reg.height == '0 || !ird_reg.pix
                    || ird_reg.rows >= ird_reg.height)
                begin
                    ihead_next  = (ihead_reg == ILAST) ? '0 : ihead_reg + 1'b1;
                    icount_next = icount_reg - 1'b1;
                end
            end
            S_IDIV:
            begin
                div_start = 1'b0;
            end
            S_IROW:
            begin
                if (div_q >= 24'(rrem))
                begin
                    rows_n      = rrem;
                    budget_next = budget_reg - prod[23:0];
                end
                else
                begin
                    rows_n      = div_q[13:0] + 14'(div_r != '0);
                    budget_next = '0;
                end
                rows_new    = ird_reg.rows + rows_n;
                strobe_next = 1'b1;
                tv_next     = 1'b1;
                tag_next    = ird_reg.tag;
                tgt_next    = TGT_IMAGE;
                off_next    = 24'(ird_reg.rows);
                len_next    = 24'(rows_n);
                jd_next     = (rows_new == ird_reg.height);
                iwr_en      = 1'b1;
                iwr_addr    = ihead_reg;
                iwr_data    = '{tag: ird_reg.tag, width: ird_reg.width,
                                height: ird_reg.height, rgba: ird_reg.rgba,
                                pix: ird_reg.pix, rows: rows_new};
                if (rows_new == ird_reg.height)
                begin
                    ihead_next  = (ihead_reg == ILAST) ? '0 : ihead_reg + 1'b1;
                    icount_next = icount_reg - 1'b1;
                end
            end
            S_STAT:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                stat_next   = (bcount_reg == '0 && icount_reg == '0) ? STAT_DONE : STAT_BUSY;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase

        if (state_reg == S_ICHK && state_next == S_IDIV)
        begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bwr_en)
        begin
            bmem[bwr_addr] <= bwr_data;
        end
        if (brd_en)
        begin
            brd_reg <= bmem[bhead_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (iwr_en)
        begin
            imem[iwr_addr] <= iwr_data;
        end
        if (ird_en)
        begin
            ird_reg <= imem[ihead_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bhead_reg   <= '0;
            bcount_reg  <= '0;
            ihead_reg   <= '0;
            icount_reg  <= '0;
            budget_reg  <= '0;
            fbudget_reg <= FRAME_BUDGET_RESET;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bhead_reg  <= bhead_next;
            bcount_reg <= bcount_next;
            ihead_reg  <= ihead_next;
            icount_reg <= icount_next;
            budget_reg <= budget_next;
            strobe_reg <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                fbudget_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg   <= wv_next;
        bpr_reg  <= bpr_next;
        tv_reg   <= tv_next;
        tag_reg  <= tag_next;
        tgt_reg  <= tgt_next;
        off_reg  <= off_next;
        len_reg  <= len_next;
        jd_reg   <= jd_next;
        acc_reg  <= acc_next;
        stat_reg <= stat_next;
        last_reg <= last_next;
    end

    assign result_strobe  = strobe_reg;
    assign transfer_valid = tv_reg;
    assign out_tag        = tag_reg;
    assign target         = tgt_reg;
    assign chunk_offset   = off_reg;
    assign chunk_length   = len_reg;
    assign job_done       = jd_reg;
    assign accepted       = acc_reg;
    assign status         = stat_reg;
    assign last           = last_reg;

    `BCUS_ASSERT_NOW(a_bcount_range, 1'b1, {1'b0, bcount_reg} <= BDEPTH, "buffer count overflow")
    `BCUS_ASSERT_NOW(a_icount_range, 1'b1, {1'b0, icount_reg} <= IDEPTH, "image count overflow")
    `BCUS_ASSERT_NEXT(a_stat_last, state_reg == S_STAT, result_strobe && last, "tick lacks status")
    `BCUS_ASSERT_NOW(a_chunk_not_last, result_strobe && transfer_valid, !last && !accepted,
        "chunk result marked last")

endmodule
`default_nettype wire
